### rtl/core/rtul_pkg.sv
// shared types, constants and codes for the route table core
package rtul_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int TIME_BITS_DEF     = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_THR    = 1'd1;

  localparam logic [15:0]       OWN_NODE_ID_RST = 16'd0;
  localparam logic signed [7:0] RSSI_THR_RST    = -8'sd87;

  // item actions
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_KEPT     = 3'd2;
  localparam logic [2:0] ST_OWN      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              action;
    logic [15:0]       origin_node;
    logic [15:0]       sender_node;
    logic [15:0]       seq_number;
    logic [7:0]        ttl_initial;
    logic [7:0]        ttl_left;
    logic signed [7:0] rssi_dbm;
    logic [31:0]       now_time;
    logic [15:0]       lookup_dest;
  } rtul_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [15:0] next_hop;
    logic [7:0]  hop_count;
    logic [15:0] route_seq;
    logic [31:0] route_time;
  } rtul_out_t;

  // route fields kept in a cell, time stamp travels beside it
  typedef struct packed {
    logic [15:0] next_hop;
    logic [7:0]  hops;
    logic [15:0] seq;
  } rtul_route_t;

  // search token control moving down the chain
  typedef struct packed {
    logic valid;
    logic found;
  } rtul_tok_t;

  // write beat broadcast to the cells
  typedef struct packed {
    logic        insert;
    logic [15:0] dest;
    rtul_route_t route;
  } rtul_wr_t;

endpackage

### rtl/core/rtul_cell.sv
// one table cell: holds a route and passes the search token to its neighbor
module rtul_cell
  import rtul_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int IDX_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          key,
  input  rtul_tok_t            tok_in,
  input  logic [IDX_W-1:0]     idx_in,
  input  rtul_route_t          route_in,
  input  logic [TIME_BITS-1:0] time_in,
  output rtul_tok_t            tok_out,
  output logic [IDX_W-1:0]     idx_out,
  output rtul_route_t          route_out,
  output logic [TIME_BITS-1:0] time_out,
  input  logic                 wr_sel,
  input  rtul_wr_t             wr,
  input  logic [TIME_BITS-1:0] wr_time
);

  logic                 valid;
  logic [15:0]          dest;
  rtul_route_t          route;
  logic [TIME_BITS-1:0] stamp;
  logic                 hit;

  // destinations are unique in the table, so at most one cell hits
  assign hit = tok_in.valid && valid && (dest == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tok_out.valid <= 1'b0;
      tok_out.found <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | hit;
      if (wr_sel && wr.insert) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      idx_out   <= IDX_W'(CELL_INDEX);
      route_out <= route;
      time_out  <= stamp;
    end else begin
      idx_out   <= idx_in;
      route_out <= route_in;
      time_out  <= time_in;
    end
    if (wr_sel) begin
      route <= wr.route;
      stamp <= wr_time;
      if (wr.insert) begin
        dest <= wr.dest;
      end
    end
  end

endmodule

### rtl/core/route_table_update_lookup_core.sv
// top level of the route table: item register, cell chain, decision and write-back
//
// One input beat is taken at a rising edge with start high and busy low. The item
// is either an update from a received packet or a lookup of a destination.
// Configuration is written through cfg_we, cfg_index and cfg_data at any edge with
// cfg_we high; the user must write it only while the block is idle (not enforced):
// index 0 is own_node_id, index 1 is rssi_threshold_dbm; other indexes are dropped.
// The search token walks the chain of TABLE_ENTRIES cells, one cell per cycle.
// After the last cell the outcome is decided, the chosen cell, if any, is written and
// the result beat sits on result for exactly one cycle with done high. busy falls as
// done rises, so a new item can be accepted at the edge that ends the done cycle; no
// new item is taken while one is still in the chain. The receiver
// has no way to stall the block.
// Reset clears every valid bit, the fill count and any item in flight and sets both
// registers to their defaults; there is no clearing pass, the block is ready in the cycle after reset.
module route_table_update_lookup_core
  import rtul_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  rtul_in_t              item,
  output logic                  done,
  output rtul_out_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [15:0]       own_node_id;
  logic signed [7:0] rssi_thr;
  logic              head_valid;
  rtul_in_t          item_q;
  logic [15:0]       key;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_count_next;
  rtul_out_t         result_next;
  logic              accept;

  rtul_tok_t            tok   [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]     idx   [TABLE_ENTRIES+1];
  rtul_route_t          route [TABLE_ENTRIES+1];
  logic [TIME_BITS-1:0] stamp [TABLE_ENTRIES+1];

  logic [TABLE_ENTRIES-1:0] wr_sel;
  rtul_wr_t                 wr;
  logic [TIME_BITS-1:0]     wr_time;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic [7:0]               hops;
  logic                     better;
  rtul_tok_t                tail;

  assign accept = start && !busy;
  assign tail   = tok[TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id <= OWN_NODE_ID_RST;
      rssi_thr    <= RSSI_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_NODE_ID: own_node_id <= cfg_data;
        REG_RSSI_THR:    rssi_thr    <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      head_valid <= 1'b0;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      head_valid <= accept;
      done       <= tail.valid;
      fill_count <= fill_count_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      key    <= (item.action == ACT_LOOKUP) ? item.lookup_dest : item.origin_node;
    end
    if (tail.valid) begin
      result <= result_next;
    end
  end

  // head of the chain: empty token carrying the search
  assign tok[0]   = {head_valid, 1'b0};
  assign idx[0]   = '0;
  assign route[0] = '0;
  assign stamp[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign wr_sel[i] = wr_en && (wr_idx == IDX_W'(i));

    rtul_cell #(
      .TIME_BITS  (TIME_BITS),
      .IDX_W      (IDX_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .tok_in    (tok[i]),
      .idx_in    (idx[i]),
      .route_in  (route[i]),
      .time_in   (stamp[i]),
      .tok_out   (tok[i+1]),
      .idx_out   (idx[i+1]),
      .route_out (route[i+1]),
      .time_out  (stamp[i+1]),
      .wr_sel    (wr_sel[i]),
      .wr        (wr),
      .wr_time   (wr_time)
    );
  end

  // hop count saturates at zero when more ttl is left than it started with
  assign hops = (item_q.ttl_initial > item_q.ttl_left) ?
                (item_q.ttl_initial - item_q.ttl_left) : 8'd0;

  assign better = (item_q.seq_number >= route[TABLE_ENTRIES].seq) &&
                  ($signed(item_q.rssi_dbm) < rssi_thr) &&
                  (route[TABLE_ENTRIES].hops > hops);

  assign wr_time = TIME_BITS'(item_q.now_time);

  always_comb begin
    result_next       = '0;
    wr_en             = 1'b0;
    wr.insert         = 1'b0;
    wr.dest           = item_q.origin_node;
    wr.route.next_hop = item_q.sender_node;
    wr.route.hops     = hops;
    wr.route.seq      = item_q.seq_number;
    wr_idx            = idx[TABLE_ENTRIES];
    fill_count_next   = fill_count;
    if (tail.valid) begin
      if (item_q.action == ACT_LOOKUP) begin
        result_next.status = ST_KEPT;
        if (tail.found) begin
          result_next.found      = 1'b1;
          result_next.next_hop   = route[TABLE_ENTRIES].next_hop;
          result_next.hop_count  = route[TABLE_ENTRIES].hops;
          result_next.route_seq  = route[TABLE_ENTRIES].seq;
          result_next.route_time = 32'(stamp[TABLE_ENTRIES]);
        end
      end else if (item_q.origin_node == own_node_id) begin
        result_next.status = ST_OWN;
      end else if (tail.found) begin
        if (better) begin
          result_next.status = ST_UPDATED;
          wr_en              = 1'b1;
        end else begin
          result_next.status = ST_KEPT;
        end
      end else if (fill_count == CNT_W'(TABLE_ENTRIES)) begin
        result_next.status = ST_FULL;
      end else begin
        result_next.status = ST_INSERTED;
        wr_en              = 1'b1;
        wr.insert          = 1'b1;
        wr_idx             = fill_count[IDX_W-1:0];
        fill_count_next    = fill_count + CNT_W'(1);
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while a search is still in flight");

  a_tail_busy: assert property (@(posedge clk) disable iff (rst) tail.valid |-> busy)
    else $error("search token at the chain end with no item accepted");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_wr_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_sel) && (!wr_en || tail.valid))
    else $error("write beat selects more than one cell or comes outside the decision");

  a_head_pulse: assert property (@(posedge clk) disable iff (rst)
    head_valid |=> !head_valid)
    else $error("search token entered the chain twice for one item");

endmodule

### tb/route_table_update_lookup_core_test.sv
// self-checking testbench for the route table update and lookup core
module route_table_update_lookup_core_test;
  import rtul_pkg::*;

  localparam int SLOTS          = TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE      = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  rtul_in_t              item = '0;
  logic                  done;
  rtul_out_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_OWN_NODE_ID;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  route_table_update_lookup_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the routing table and registers
  logic              route_valid [SLOTS];
  logic [15:0]       route_dest  [SLOTS];
  logic [15:0]       route_next  [SLOTS];
  logic [7:0]        route_hops  [SLOTS];
  logic [15:0]       route_seq   [SLOTS];
  logic [31:0]       route_time  [SLOTS];
  int                route_fill = 0;
  logic [15:0]       node_id = OWN_NODE_ID_RST;
  logic signed [7:0] rssi_limit = RSSI_THR_RST;

  rtul_out_t   results_due [$];
  logic [15:0] origin_pool [POOL_SIZE];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          max_gap = 18;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (route_valid[i]) route_valid[i] = 1'b0;
  end

  function automatic int find_route(input logic [15:0] dest);
    for (int i = 0; i < SLOTS; i++) begin
      if (route_valid[i] && route_dest[i] == dest) return i;
    end
    return -1;
  endfunction

  // expected result of one beat, applied to the shadow table
  function automatic rtul_out_t route_outcome(input rtul_in_t beat);
    rtul_out_t  res;
    int         slot;
    logic [7:0] hops;
    res = '0;
    if (beat.action == ACT_LOOKUP) begin
      res.status = ST_KEPT;
      slot = find_route(beat.lookup_dest);
      if (slot >= 0) begin
        res.found      = 1'b1;
        res.next_hop   = route_next[slot];
        res.hop_count  = route_hops[slot];
        res.route_seq  = route_seq[slot];
        res.route_time = route_time[slot];
      end
      return res;
    end
    if (beat.origin_node == node_id) begin
      res.status = ST_OWN;
      return res;
    end
    hops = (beat.ttl_initial > beat.ttl_left) ? beat.ttl_initial - beat.ttl_left : 8'd0;
    slot = find_route(beat.origin_node);
    if (slot >= 0) begin
      if (beat.seq_number >= route_seq[slot] && $signed(beat.rssi_dbm) < rssi_limit &&
          route_hops[slot] > hops) begin
        route_next[slot] = beat.sender_node;
        route_hops[slot] = hops;
        route_seq[slot]  = beat.seq_number;
        route_time[slot] = beat.now_time;
        res.status = ST_UPDATED;
      end else begin
        res.status = ST_KEPT;
      end
      return res;
    end
    if (route_fill >= SLOTS) begin
      res.status = ST_FULL;
      return res;
    end
    route_valid[route_fill] = 1'b1;
    route_dest[route_fill]  = beat.origin_node;
    route_next[route_fill]  = beat.sender_node;
    route_hops[route_fill]  = hops;
    route_seq[route_fill]   = beat.seq_number;
    route_time[route_fill]  = beat.now_time;
    route_fill++;
    res.status = ST_INSERTED;
    return res;
  endfunction

  function automatic rtul_in_t noise_beat();
    rtul_in_t beat;
    beat.action      = 1'($urandom);
    beat.origin_node = 16'($urandom);
    beat.sender_node = 16'($urandom);
    beat.seq_number  = 16'($urandom);
    beat.ttl_initial = 8'($urandom);
    beat.ttl_left    = 8'($urandom);
    beat.rssi_dbm    = 8'($urandom);
    beat.now_time    = $urandom;
    beat.lookup_dest = 16'($urandom);
    return beat;
  endfunction

  function automatic rtul_in_t make_update(input logic [15:0] origin, input logic [15:0] sender,
                                           input logic [15:0] seq, input int ttl_i,
                                           input int ttl_l, input int rssi,
                                           input logic [31:0] now);
    rtul_in_t beat;
    beat = noise_beat();
    beat.action      = ACT_UPDATE;
    beat.origin_node = origin;
    beat.sender_node = sender;
    beat.seq_number  = seq;
    beat.ttl_initial = 8'(ttl_i);
    beat.ttl_left    = 8'(ttl_l);
    beat.rssi_dbm    = 8'(rssi);
    beat.now_time    = now;
    return beat;
  endfunction

  function automatic rtul_in_t make_lookup(input logic [15:0] dest);
    rtul_in_t beat;
    beat = noise_beat();
    beat.action      = ACT_LOOKUP;
    beat.lookup_dest = dest;
    return beat;
  endfunction

  // ttl pair that gives the wanted hop count
  function automatic void set_hops(inout rtul_in_t beat, input int hops);
    beat.ttl_initial = 8'($urandom_range(hops, 255));
    beat.ttl_left    = beat.ttl_initial - 8'(hops);
  endfunction

  function automatic rtul_in_t random_beat();
    rtul_in_t beat;
    int       pick;
    int       slot;
    int       hops;
    int       span;
    beat = noise_beat();
    pick = $urandom_range(0, 99);
    if (pick < 10) return beat;
    if (pick < 35) begin
      beat.action = ACT_LOOKUP;
      if ($urandom_range(0, 4) != 0)
        beat.lookup_dest = origin_pool[$urandom_range(0, POOL_SIZE - 1)];
      return beat;
    end
    beat.action = ACT_UPDATE;
    if (pick < 75 && route_fill > 0) begin
      // well-formed improvement of a known route
      slot = $urandom_range(0, route_fill - 1);
      beat.origin_node = route_dest[slot];
      hops = route_hops[slot];
      if (hops > 0) hops -= $urandom_range(1, (hops < 3) ? hops : 3);
      set_hops(beat, hops);
      beat.seq_number = (route_seq[slot] > 16'hfffc) ? 16'hffff :
                        route_seq[slot] + 16'($urandom_range(0, 3));
      if (rssi_limit > -128) begin
        span = int'(rssi_limit) + 127;
        beat.rssi_dbm = 8'(-128 + int'($urandom_range(0, span)));
      end
      return beat;
    end
    beat.origin_node = origin_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 19) == 0) beat.origin_node = node_id;
    if ($urandom_range(0, 4) != 0) set_hops(beat, $urandom_range(0, 255));
    return beat;
  endfunction

  // start stays high when the next beat follows at once
  task automatic send_item(input rtul_in_t beat);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
    results_due.push_back(route_outcome(beat));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    wait (results_due.size() == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OWN_NODE_ID) node_id = data;
    else rssi_limit = $signed(data[7:0]);
  endtask

  task automatic test_empty_table();
    send_item(make_lookup(16'h0000));
    send_item(make_lookup(16'hffff));
  endtask

  task automatic test_own_packets();
    send_item(make_update(16'h0000, 16'h5555, 16'h0001, 10, 3, -100, 32'h1));
    wait_for_results();
    write_reg(REG_OWN_NODE_ID, 16'hffff);
    send_item(make_update(16'hffff, 16'h0000, 16'hffff, 255, 0, -128, 32'hffff_ffff));
    // origin 0 is no longer this node, so it gets a route with the most hops
    send_item(make_update(16'h0000, 16'hffff, 16'h0000, 255, 0, 127, 32'hffff_ffff));
    send_item(make_lookup(16'h0000));
  endtask

  task automatic test_route_rules();
    send_item(make_update(16'h1234, 16'h0101, 16'd100, 200, 0, -100, 32'h0000_1000));
    send_item(make_update(16'h1234, 16'h0202, 16'd99, 20, 10, -100, 32'h0000_2000));
    // rssi equal to the threshold is not below it
    send_item(make_update(16'h1234, 16'h0303, 16'd200, 20, 10, -87, 32'h0000_3000));
    send_item(make_update(16'h1234, 16'h0404, 16'd200, 200, 0, -120, 32'h0000_4000));
    send_item(make_update(16'h1234, 16'h0505, 16'd100, 150, 0, -128, 32'h0000_5000));
    // ttl left above the initial ttl gives zero hops
    send_item(make_update(16'h1234, 16'hfffe, 16'hffff, 5, 9, -88, 32'h8000_0000));
    send_item(make_update(16'h1234, 16'h0606, 16'hffff, 0, 0, -128, 32'h0000_6000));
    send_item(make_lookup(16'h1234));
  endtask

  task automatic test_threshold_extremes();
    wait_for_results();
    write_reg(REG_RSSI_THR, {8'($urandom), 8'sd127});
    send_item(make_update(16'h00ff, 16'h0a0a, 16'h7fff, 50, 0, 0, 32'h1234_5678));
    send_item(make_update(16'h00ff, 16'h0b0b, 16'h7fff, 40, 0, 127, 32'h1111_1111));
    send_item(make_update(16'h00ff, 16'h0c0c, 16'h8000, 45, 5, 126, 32'h2222_2222));
    wait_for_results();
    write_reg(REG_RSSI_THR, {8'($urandom), -8'sd128});
    send_item(make_update(16'h00ff, 16'h0d0d, 16'hffff, 1, 0, -128, 32'h3333_3333));
    send_item(make_lookup(16'h00ff));
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    foreach (origin_pool[i]) origin_pool[i] = 16'($urandom);
    for (phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        0: write_reg(REG_OWN_NODE_ID, 16'($urandom));
        1: write_reg(REG_OWN_NODE_ID, 16'hffff);
        3: write_reg(REG_OWN_NODE_ID, 16'h0000);
        default: write_reg(REG_OWN_NODE_ID, origin_pool[$urandom_range(0, POOL_SIZE - 1)]);
      endcase
      case (phase)
        0: write_reg(REG_RSSI_THR, {8'($urandom), 8'sd127});
        2: write_reg(REG_RSSI_THR, {8'($urandom), -8'sd128});
        3: write_reg(REG_RSSI_THR, {8'($urandom), RSSI_THR_RST});
        default: write_reg(REG_RSSI_THR, 16'($urandom));
      endcase
      // one phase with back-to-back beats
      max_gap = (phase == 2) ? 0 : 18;
      for (n = 0; n < 135; n++) begin
        if ($urandom_range(0, 49) == 0) wait_for_results();
        send_item(random_beat());
      end
    end
    max_gap = 18;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    rtul_out_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %p", $time, result);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("found", 32'(want.found), 32'(result.found));
        check_field("next_hop", 32'(want.next_hop), 32'(result.next_hop));
        check_field("hop_count", 32'(want.hop_count), 32'(result.hop_count));
        check_field("route_seq", 32'(want.route_seq), 32'(result.route_seq));
        check_field("route_time", want.route_time, result.route_time);
      end
    end
  end

  // counts cycles with no beat moving in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_own_packets();
    test_route_rules();
    test_threshold_extremes();
    test_random_traffic();
    wait_for_results();
    repeat (SLOTS + 4) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
